// File: rtl/trs_world_matrix_compose_top_defines.svh
// Assertion macros shared by the world matrix compose RTL.
`ifndef TRS_WORLD_MATRIX_COMPOSE_TOP_DEFINES_SVH
`define TRS_WORLD_MATRIX_COMPOSE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TWMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TWMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/twmc_pkg.sv
// Types, constants and helpers for the world matrix compose block.
package twmc_pkg;

  localparam int DEF_NODE_SLOTS = 64;
  localparam int WORDS_PER_SLOT = 12;
  localparam int RAW_SLOTS      = 64;

  localparam logic signed [35:0] ONE_Q28    = 36'sd268435456;
  localparam logic signed [35:0] HALF_Q12   = 36'sd2048;
  localparam logic signed [65:0] HALF_Q16   = 66'sd32768;
  localparam logic signed [31:0] ONE_Q16    = 32'sd65536;
  localparam logic signed [65:0] SAT_MAX    = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN    = -66'sd2147483648;

  // quaternion component selectors
  localparam logic [1:0] CMP_X = 2'd0;
  localparam logic [1:0] CMP_Y = 2'd1;
  localparam logic [1:0] CMP_Z = 2'd2;
  localparam logic [1:0] CMP_W = 2'd3;

  // operand pairs of the nine raw rotation products: xx xy xz yy yz zz wx wy wz
  localparam logic [1:0] ROT_A [9] = '{CMP_X, CMP_X, CMP_X, CMP_Y, CMP_Y, CMP_Z,
                                       CMP_W, CMP_W, CMP_W};
  localparam logic [1:0] ROT_B [9] = '{CMP_X, CMP_Y, CMP_Z, CMP_Y, CMP_Z, CMP_Z,
                                       CMP_X, CMP_Y, CMP_Z};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_RQ,
    ST_LOC,
    ST_WLD,
    ST_DRAIN,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ROT,
    OP_LOC,
    OP_WLD
  } op_t;

  // travels with each product through the multiplier
  typedef struct packed {
    op_t        kind;
    logic [3:0] idx;
    logic       first;
    logic       last;
  } mul_tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/trs_world_matrix_compose_top.sv
// Top level of the world matrix compose block: sequencer, stores and output rows.
//
// Usage:
//   An item (node slot, parent slot, translation, quaternion, scale) is taken
//   at a rising edge with start high and busy low. busy then stays high while
//   the block works on it; no other item is taken meanwhile.
//   The block builds Translate*Rotate*Scale in Q16.16, multiplies the parent's
//   stored world matrix on the left when the parent slot differs from the node
//   slot, writes the 3x4 result into the node's slot and emits three rows.
//   Each row is shown for one cycle with out_valid high; row 2 carries
//   out_last_row. The receiver cannot stall the rows.
// Multiplier use:
//   One 32x32 multiplier is shared by every product: 9 quaternion products,
//   9 rotation*scale products, and 39 parent products (3 per element, 4 for
//   the translation column). The last row shows in the first cycle busy is
//   low, so the next item can be taken while that row shows. The parent's 12
//   words are fetched from the store while the local matrix is being built.
// Reset:
//   rst_n low returns the sequencer to idle and drops out_valid. The matrix
//   store is not cleared; a parent slot must be written before it is read.
`include "trs_world_matrix_compose_top_defines.svh"

module trs_world_matrix_compose_top #(
  parameter int NODE_SLOTS = twmc_pkg::DEF_NODE_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         in_node_slot,
  input  logic [5:0]         in_parent_slot,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_rot_x,
  input  logic signed [15:0] in_rot_y,
  input  logic signed [15:0] in_rot_z,
  input  logic signed [15:0] in_rot_w,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  output logic               out_valid,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_last_row
);
  import twmc_pkg::*;

  localparam int DEPTH = NODE_SLOTS * WORDS_PER_SLOT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  // ---------------------------------------------------------------------
  // slot wrap: raw 6-bit slot modulo NODE_SLOTS, as a constant table
  // ---------------------------------------------------------------------
  logic [SW-1:0] slot_lut [RAW_SLOTS];
  for (genvar v = 0; v < RAW_SLOTS; v++) begin : g_slot
    assign slot_lut[v] = SW'(v % NODE_SLOTS);
  end

  logic [AW-1:0] node_base, par_base;
  assign node_base = (AW'(slot_lut[in_node_slot]) << 3) + (AW'(slot_lut[in_node_slot]) << 2);
  assign par_base  = (AW'(slot_lut[in_parent_slot]) << 3)
                   + (AW'(slot_lut[in_parent_slot]) << 2);

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  st_t        st_r, st_nxt;
  logic [3:0] i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic       has_par_r;

  // world element: row i_r[3:2], column i_r[1:0]; j_r is the term
  logic wld_last;
  assign wld_last = (i_r[1:0] == 2'd3) ? (j_r == 2'd3) : (j_r == 2'd2);

  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    j_nxt  = j_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt = ST_ROT;
          i_nxt  = 4'd0;
          j_nxt  = 2'd0;
        end
      end
      ST_ROT: begin
        i_nxt = i_r + 4'd1;
        if (i_r == 4'd8) begin
          st_nxt = ST_RQ;
          i_nxt  = 4'd0;
        end
      end
      ST_RQ: begin
        i_nxt = i_r + 4'd1;
        if (i_r == 4'd1) begin
          st_nxt = ST_LOC;
          i_nxt  = 4'd0;
          j_nxt  = 2'd0;
        end
      end
      ST_LOC: begin
        if (j_r == 2'd2) begin
          j_nxt = 2'd0;
          i_nxt = i_r + 4'd1;
          if (i_r == 4'd2) begin
            st_nxt = has_par_r ? ST_WLD : ST_DRAIN;
            i_nxt  = 4'd0;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_WLD: begin
        if (wld_last) begin
          j_nxt = 2'd0;
          i_nxt = i_r + 4'd1;
          if (i_r == 4'd11) begin
            st_nxt = ST_DRAIN;
            i_nxt  = 4'd0;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        i_nxt = i_r + 4'd1;
        if (i_r == 4'd2) begin
          st_nxt = ST_OUT;
          i_nxt  = 4'd0;
        end
      end
      ST_OUT: begin
        i_nxt = i_r + 4'd1;
        if (i_r == 4'd11) begin
          st_nxt = ST_IDLE;
          i_nxt  = 4'd0;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      i_r  <= 4'd0;
      j_r  <= 2'd0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
    end
  end

  assign busy = (st_r != ST_IDLE);

  // ---------------------------------------------------------------------
  // item registers
  // ---------------------------------------------------------------------
  logic signed [15:0] q_r   [4];
  logic signed [31:0] scl_r [3];
  logic [AW-1:0]      node_base_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[CMP_X]  <= in_rot_x;
      q_r[CMP_Y]  <= in_rot_y;
      q_r[CMP_Z]  <= in_rot_z;
      q_r[CMP_W]  <= in_rot_w;
      scl_r[0]    <= in_scale_x;
      scl_r[1]    <= in_scale_y;
      scl_r[2]    <= in_scale_z;
      node_base_r <= node_base;
      has_par_r   <= (in_node_slot != in_parent_slot);
    end
  end

  // ---------------------------------------------------------------------
  // world store and parent fetch
  // ---------------------------------------------------------------------
  logic [31:0]        mem [DEPTH];
  logic [31:0]        mem_q_r;
  logic               rd_act_r, rd_vld_r;
  logic [3:0]         rd_cnt_r;
  logic [AW-1:0]      rd_base_r;
  logic signed [31:0] par_r [WORDS_PER_SLOT];
  logic signed [31:0] wr_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      rd_vld_r <= 1'b0;
      rd_cnt_r <= 4'd0;
    end else begin
      rd_vld_r <= rd_act_r;
      if (accept) begin
        rd_act_r <= 1'b1;
        rd_cnt_r <= 4'd0;
      end else if (rd_act_r) begin
        rd_cnt_r <= rd_cnt_r + 4'd1;
        if (rd_cnt_r == 4'(WORDS_PER_SLOT - 1)) begin
          rd_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_base_r <= par_base;
    end
    if (rd_act_r) begin
      mem_q_r <= mem[rd_base_r + AW'(rd_cnt_r)];
    end
    if (st_r == ST_OUT) begin
      mem[node_base_r + AW'(i_r)] <= wr_word;
    end
  end

  // parent words shift in, word 0 ends in par_r[0]
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int k = 0; k < WORDS_PER_SLOT - 1; k++) begin
        par_r[k] <= par_r[k+1];
      end
      par_r[WORDS_PER_SLOT-1] <= mem_q_r;
    end
  end

  // ---------------------------------------------------------------------
  // shared multiplier: operand select
  // ---------------------------------------------------------------------
  logic signed [31:0] ma, mb;
  mul_tag_t           tag_iss, tag_res;
  logic signed [63:0] mprod;

  logic signed [23:0] rq_r  [9];
  logic signed [31:0] loc_r [WORDS_PER_SLOT];
  logic [3:0]         rq_idx;
  logic [1:0]         loc_row;

  assign rq_idx  = {1'b0, i_r[1:0], 1'b0} + {2'b00, i_r[1:0]} + {2'b00, j_r};
  assign loc_row = (j_r == 2'd3) ? 2'd0 : j_r;

  always_comb begin
    ma      = 32'sd0;
    mb      = 32'sd0;
    tag_iss = '{kind: OP_NONE, idx: 4'd0, first: 1'b0, last: 1'b0};
    unique case (st_r)
      ST_ROT: begin
        ma      = 32'(q_r[ROT_A[i_r]]);
        mb      = 32'(q_r[ROT_B[i_r]]);
        tag_iss = '{kind: OP_ROT, idx: i_r, first: 1'b0, last: 1'b0};
      end
      ST_LOC: begin
        ma      = 32'(rq_r[rq_idx]);
        mb      = scl_r[j_r];
        tag_iss = '{kind: OP_LOC, idx: {i_r[1:0], j_r}, first: 1'b0, last: 1'b0};
      end
      ST_WLD: begin
        // fourth term of the translation column adds the parent's offset
        ma      = par_r[{i_r[3:2], j_r}];
        mb      = (j_r == 2'd3) ? ONE_Q16 : loc_r[{loc_row, i_r[1:0]}];
        tag_iss = '{kind: OP_WLD, idx: i_r, first: (j_r == 2'd0), last: wld_last};
      end
      ST_IDLE, ST_RQ, ST_DRAIN, ST_OUT: begin
        tag_iss = '{kind: OP_NONE, idx: 4'd0, first: 1'b0, last: 1'b0};
      end
      default: begin
        tag_iss = '{kind: OP_NONE, idx: 4'd0, first: 1'b0, last: 1'b0};
      end
    endcase
  end

  twmc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .a       (ma),
    .b       (mb),
    .tag_in  (tag_iss),
    .prod    (mprod),
    .tag_out (tag_res)
  );

  // ---------------------------------------------------------------------
  // rotation terms: R = 1 - 2(..), rounded from Q.28 to Q.16
  // ---------------------------------------------------------------------
  logic signed [31:0] prod_r [9];
  logic signed [35:0] pd     [9];
  logic signed [35:0] rot    [9];
  logic signed [35:0] rot_rnd[9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pd[k] = 36'(prod_r[k]) <<< 1;
    end
    rot[0] = ONE_Q28 - (pd[3] + pd[5]);
    rot[1] = pd[1] - pd[8];
    rot[2] = pd[2] + pd[7];
    rot[3] = pd[1] + pd[8];
    rot[4] = ONE_Q28 - (pd[0] + pd[5]);
    rot[5] = pd[4] - pd[6];
    rot[6] = pd[2] - pd[7];
    rot[7] = pd[4] + pd[6];
    rot[8] = ONE_Q28 - (pd[0] + pd[3]);
    for (int k = 0; k < 9; k++) begin
      rot_rnd[k] = (rot[k] + HALF_Q12) >>> 12;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RQ) begin
      for (int k = 0; k < 9; k++) begin
        rq_r[k] <= rot_rnd[k][23:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // product consumer
  // ---------------------------------------------------------------------
  logic signed [65:0] acc_r, sum_r;
  logic signed [65:0] mprod_x;
  logic               fin_r;
  logic [3:0]         fin_idx_r;
  logic signed [31:0] res_r [WORDS_PER_SLOT];

  assign mprod_x = 66'(mprod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= (tag_res.kind == OP_WLD) && tag_res.last;
    end
  end

  always_ff @(posedge clk) begin
    fin_idx_r <= tag_res.idx;
    unique case (tag_res.kind)
      OP_ROT: begin
        prod_r[tag_res.idx] <= mprod[31:0];
      end
      OP_LOC: begin
        loc_r[tag_res.idx] <= sat32((mprod_x + HALF_Q16) >>> 16);
      end
      OP_WLD: begin
        // rounding half goes in with the first term
        if (tag_res.first) begin
          acc_r <= mprod_x + HALF_Q16;
        end else if (tag_res.last) begin
          sum_r <= acc_r + mprod_x;
        end else begin
          acc_r <= acc_r + mprod_x;
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
    if (fin_r) begin
      res_r[fin_idx_r] <= sat32(sum_r >>> 16);
    end
    // translation column of the local matrix is the item's position
    if (accept) begin
      loc_r[3]  <= in_pos_x;
      loc_r[7]  <= in_pos_y;
      loc_r[11] <= in_pos_z;
    end
  end

  // ---------------------------------------------------------------------
  // write-back and output rows
  // ---------------------------------------------------------------------
  logic [3:0] row_base;
  logic       out_valid_r, out_last_r;
  logic [1:0] out_row_r;
  logic signed [31:0] out_c_r [4];

  assign wr_word  = has_par_r ? res_r[i_r] : loc_r[i_r];
  assign row_base = {i_r[3:2], 2'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (st_r == ST_OUT) && (i_r[1:0] == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_OUT) && (i_r[1:0] == 2'd3)) begin
      out_row_r  <= i_r[3:2];
      out_last_r <= (i_r[3:2] == 2'd2);
      for (int c = 0; c < 4; c++) begin
        out_c_r[c] <= has_par_r ? res_r[row_base + 4'(c)] : loc_r[row_base + 4'(c)];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col0      = out_c_r[0];
  assign out_col1      = out_c_r[1];
  assign out_col2      = out_c_r[2];
  assign out_col3      = out_c_r[3];
  assign out_last_row  = out_last_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `TWMC_ASSERT_NXT(a_accept_busy, accept, busy, "busy not raised after item taken")
  `TWMC_ASSERT_IMP(a_fetch_done, st_r == ST_OUT, !rd_act_r, "parent fetch overlaps write-back")
  `TWMC_ASSERT_IMP(a_row_gap, out_valid && (out_row_index == 2'd1),
                   $past(out_valid, 4) && ($past(out_row_index, 4) == 2'd0),
                   "row 1 not four cycles after row 0")
  `TWMC_ASSERT_IMP(a_no_mul_idle, st_r == ST_OUT, tag_res.kind == OP_NONE,
                   "product still in flight at write-back")

endmodule

// File: rtl/twmc_mul.sv
// Shared registered 32x32 signed multiplier with a tag carried alongside.
module twmc_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [31:0]        a,
  input  logic signed [31:0]        b,
  input  twmc_pkg::mul_tag_t        tag_in,
  output logic signed [63:0]        prod,
  output twmc_pkg::mul_tag_t        tag_out
);
  import twmc_pkg::*;

  logic signed [63:0] prod_r;
  mul_tag_t           tag_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '{kind: OP_NONE, idx: 4'd0, first: 1'b0, last: 1'b0};
    end else begin
      tag_r <= tag_in;
    end
  end

  assign prod    = prod_r;
  assign tag_out = tag_r;

endmodule

// File: dv/trs_world_matrix_compose_top_test.sv
// Self-checking testbench for the world matrix compose block.
module trs_world_matrix_compose_top_test;
  import twmc_pkg::*;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0, c1, c2, c3;
    logic               last;
  } matrix_row_t;

  int error_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Holds the expected world store and the queue of expected rows.
  class world_row_scoreboard;
    logic signed [31:0] world_mem [64][12];
    bit                 slot_written [64];
    matrix_row_t        pending_rows [$];

    function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Builds T*R*S, composes with the parent and queues three rows.
    function automatic void note_item(input logic [5:0] node, input logic [5:0] parent,
                                      input logic signed [31:0] pos [3],
                                      input logic signed [15:0] q [4],
                                      input logic signed [31:0] scl [3]);
      logic signed [63:0] x, y, z, w, rot [9], loc [12], rq;
      // three full-range products need more than 64 bits
      logic signed [65:0] acc;
      logic signed [31:0] res [12];
      matrix_row_t        mr;
      x = 64'(q[0]); y = 64'(q[1]); z = 64'(q[2]); w = 64'(q[3]);
      rot[0] = (64'sd1 <<< 28) - (y*2*y + z*2*z);
      rot[1] = x*2*y - w*2*z;
      rot[2] = x*2*z + w*2*y;
      rot[3] = x*2*y + w*2*z;
      rot[4] = (64'sd1 <<< 28) - (x*2*x + z*2*z);
      rot[5] = y*2*z - w*2*x;
      rot[6] = x*2*z - w*2*y;
      rot[7] = y*2*z + w*2*x;
      rot[8] = (64'sd1 <<< 28) - (x*2*x + y*2*y);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rq = (rot[r*3+c] + 64'sd2048) >>> 12;
          loc[r*4+c] = clip32(round_q16(rq * 64'(scl[c])));
        end
        loc[r*4+3] = 64'(pos[r]);
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++) begin
          if (node != parent) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
              acc += 66'(world_mem[parent][r*4+k]) * 66'(loc[k*4+c]);
            acc = (acc + 66'sd32768) >>> 16;
            if (c == 3) acc += 66'(world_mem[parent][r*4+3]);
            res[r*4+c] = clip32(acc[63:0]);
          end else begin
            res[r*4+c] = loc[r*4+c][31:0];
          end
        end
      for (int i = 0; i < 12; i++) world_mem[node][i] = res[i];
      slot_written[node] = 1;
      for (int r = 0; r < 3; r++) begin
        mr.row = 2'(r); mr.c0 = res[r*4]; mr.c1 = res[r*4+1];
        mr.c2 = res[r*4+2]; mr.c3 = res[r*4+3]; mr.last = (r == 2);
        pending_rows.push_back(mr);
      end
    endfunction

    task automatic check_row(input matrix_row_t got);
      matrix_row_t exp_row;
      if (pending_rows.size() == 0) begin
        report_mismatch("row with no item pending");
        return;
      end
      exp_row = pending_rows.pop_front();
      if (got.row !== exp_row.row)
        report_mismatch($sformatf("row_index %0d exp %0d", got.row, exp_row.row));
      if (got.c0 !== exp_row.c0) report_mismatch($sformatf("col0 %h exp %h", got.c0, exp_row.c0));
      if (got.c1 !== exp_row.c1) report_mismatch($sformatf("col1 %h exp %h", got.c1, exp_row.c1));
      if (got.c2 !== exp_row.c2) report_mismatch($sformatf("col2 %h exp %h", got.c2, exp_row.c2));
      if (got.c3 !== exp_row.c3) report_mismatch($sformatf("col3 %h exp %h", got.c3, exp_row.c3));
      if (got.last !== exp_row.last)
        report_mismatch($sformatf("last_row %b exp %b", got.last, exp_row.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [5:0] in_node_slot = 0, in_parent_slot = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [15:0] in_rot_x = 0, in_rot_y = 0, in_rot_z = 0, in_rot_w = 0;
  logic signed [31:0] in_scale_x = 0, in_scale_y = 0, in_scale_z = 0;
  logic out_valid, out_last_row;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;

  world_row_scoreboard board = new();
  int idle_cycles = 0;

  always #5 clk = ~clk;

  trs_world_matrix_compose_top DUT (.*);

  // Sample at the edge: rows and accepted items are both seen here, before the
  // nonblocking updates of this step land.
  always @(posedge clk) begin
    matrix_row_t got;
    if (rst_n && out_valid) begin
      got.row = out_row_index; got.c0 = out_col0; got.c1 = out_col1;
      got.c2 = out_col2; got.c3 = out_col3; got.last = out_last_row;
      board.check_row(got);
    end
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    // Slowest honest gap is one parent item plus a long idle.
    if (idle_cycles > 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Random gap: mostly short, now and then long, sometimes none.
  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: n = 0;
      9:       n = $urandom_range(20, 120);
      default: n = $urandom_range(1, 6);
    endcase
    repeat (n) @(posedge clk);
  endtask

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic [5:0] node, input logic [5:0] parent,
                           input logic signed [31:0] pos [3],
                           input logic signed [15:0] q [4],
                           input logic signed [31:0] scl [3]);
    start <= 1;
    in_node_slot <= node; in_parent_slot <= parent;
    in_pos_x <= pos[0]; in_pos_y <= pos[1]; in_pos_z <= pos[2];
    in_rot_x <= q[0]; in_rot_y <= q[1]; in_rot_z <= q[2]; in_rot_w <= q[3];
    in_scale_x <= scl[0]; in_scale_y <= scl[1]; in_scale_z <= scl[2];
    do @(posedge clk); while (busy);
    board.note_item(node, parent, pos, q, scl);
    start <= 0;
    // block is busy now; next item is driven on a later edge
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'sh20000;
      3, 4: return $urandom_range(0, 32'h1ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_q14();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh4000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Parent is always a written slot, or the node itself.
  task automatic random_item();
    logic [5:0] node, parent;
    logic signed [31:0] pos [3], scl [3];
    logic signed [15:0] q [4];
    node = 6'($urandom);
    parent = node;
    if ($urandom_range(0, 3) != 0) begin
      parent = 6'($urandom);
      while (!board.slot_written[parent]) parent = 6'($urandom);
    end
    foreach (pos[i]) pos[i] = pick_q16();
    foreach (scl[i]) scl[i] = pick_q16();
    foreach (q[i]) q[i] = pick_q14();
    send_item(node, parent, pos, q, scl);
  endtask

  initial begin
    logic signed [31:0] pos [3], scl [3];
    logic signed [15:0] q [4];
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Identity root, unit scale.
    pos = '{32'sh10000, -32'sh20000, 0}; q = '{0, 0, 0, 16'sh4000};
    scl = '{32'sh10000, 32'sh10000, 32'sh10000};
    send_item(0, 0, pos, q, scl);
    // Child of identity, 90 degrees about z, half scale.
    pos = '{32'sh30000, 0, 32'sh8000}; q = '{0, 0, 16'sh2d41, 16'sh2d41};
    scl = '{32'sh8000, 32'sh8000, 32'sh8000};
    send_item(1, 0, pos, q, scl);
    // Grandchild.
    send_item(2, 1, pos, q, scl);
    // Extremes: saturating translation and scale, unnormalized quaternion.
    pos = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    scl = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_item(63, 63, pos, q, scl);
    send_item(3, 63, pos, q, scl);
    q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_item(63, 3, pos, q, scl);
    // Zero quaternion and zero scale; all-ones fields.
    pos = '{0, 0, 0}; q = '{0, 0, 0, 0}; scl = '{0, 0, 0};
    send_item(62, 62, pos, q, scl);
    pos = '{-1, -1, -1}; q = '{-1, -1, -1, -1}; scl = '{-1, -1, -1};
    send_item(4, 2, pos, q, scl);
    // Node overwrites its own parent slot.
    send_item(1, 1, pos, q, scl);
    send_item(2, 2, pos, q, scl);

    repeat (280) begin
      idle_gap();
      random_item();
    end

    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
